[rtl/uartfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// uartfr_pkg
// Shared types and constants of the UART receive line and packet framer.
// ============================================================================
package uartfr_pkg;

    localparam int unsigned DEFAULT_STORE_BYTES = 64;
    localparam int unsigned RUN_LIMIT           = 64;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_SIZE  = 2'd1;

    localparam logic [KIND_W-1:0] KIND_PACKET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [CNT_W-1:0] PACKET_SIZE_RESET = 7'd8;
    localparam logic [CNT_W-1:0] PACKET_SIZE_MIN   = 7'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_lf;
    } q_item_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_PUSH  = 4'b0100,
        ST_TAIL  = 4'b1000
    } back_state_t;

endpackage
`default_nettype wire

[rtl/uartfr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// uartfr_front
// Accepts received bytes, marks line feeds and holds them in a short queue
// for the framing engine.
// ============================================================================
module uartfr_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [uartfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                               q_valid,
    output uartfr_pkg::q_item_t                q_item,
    input  wire logic                          q_pop
);
    import uartfr_pkg::*;

    q_item_t             q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    q_item_t             new_item;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.data  = rx_byte;
        new_item.is_lf = (rx_byte == LINE_FEED);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

[rtl/uartfr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// uartfr_back
// Framing engine: byte store, line and packet window bookkeeping, checksum
// test and emission of runs through an output register.
// ============================================================================
module uartfr_back
#(
    parameter int unsigned STORE_BYTES = uartfr_pkg::DEFAULT_STORE_BYTES
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire uartfr_pkg::q_item_t               q_item,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [uartfr_pkg::BYTE_W-1:0]          out_byte,
    output logic                                   last,
    output logic [uartfr_pkg::KIND_W-1:0]          kind,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [uartfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uartfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uartfr_pkg::*;

    localparam int unsigned IDX_W  = $clog2(STORE_BYTES);
    localparam int unsigned SLOT_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int unsigned CAP    = (STORE_BYTES < RUN_LIMIT) ? STORE_BYTES : RUN_LIMIT;
    localparam logic [CNT_W-1:0]  CAP_C      = CNT_W'(CAP);
    localparam logic [CNT_W-1:0]  CAP_LINE   = CNT_W'(CAP - 1);
    localparam logic [IDX_W-1:0]  SLOT_LAST  = IDX_W'(STORE_BYTES - 1);
    localparam logic [SLOT_W-1:0] SLOT_COUNT = SLOT_W'(STORE_BYTES);

    logic [BYTE_W-1:0] store_mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    back_state_t       state_reg,   state_next;
    logic [CNT_W-1:0]  fill_reg,    fill_next;
    logic [IDX_W-1:0]  oldest_reg,  oldest_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [IDX_W-1:0]  ptr_reg,     ptr_next;
    logic [CNT_W-1:0]  remain_reg,  remain_next;
    logic              run_line_reg, run_line_next;
    logic              marker_reg,  marker_next;
    logic              mode_reg,    mode_next;
    logic [CNT_W-1:0]  psize_reg,   psize_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,  out_byte_next;
    logic              last_reg,      last_next;
    logic [KIND_W-1:0] kind_reg,      kind_next;

    logic              out_free;
    logic              wr_en;
    logic [SLOT_W-1:0] slot_sum;
    logic [IDX_W-1:0]  wr_slot;
    logic [CNT_W-1:0]  psize_eff;
    logic [CNT_W-1:0]  fill_inc;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign kind      = kind_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign fill_inc  = fill_reg + 1'b1;

    always_comb
    begin
        if (psize_reg < PACKET_SIZE_MIN)
        begin
            psize_eff = PACKET_SIZE_MIN;
        end
        else if (psize_reg > CAP_C)
        begin
            psize_eff = CAP_C;
        end
        else
        begin
            psize_eff = psize_reg;
        end
    end

    always_comb
    begin
        slot_sum = SLOT_W'(oldest_reg) + SLOT_W'(fill_reg);
        if (slot_sum >= SLOT_COUNT)
        begin
            wr_slot = IDX_W'(slot_sum - SLOT_COUNT);
        end
        else
        begin
            wr_slot = IDX_W'(slot_sum);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        sum_next       = sum_reg;
        ptr_next       = ptr_reg;
        remain_next    = remain_reg;
        run_line_next  = run_line_reg;
        marker_next    = marker_reg;
        mode_next      = mode_reg;
        psize_next     = psize_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        kind_next      = kind_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                ptr_next = oldest_reg;
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!mode_reg)
                    begin
                        if (q_item.is_lf)
                        begin
                            remain_next   = fill_reg;
                            run_line_next = 1'b1;
                            marker_next   = 1'b0;
                            fill_next     = '0;
                            oldest_next   = '0;
                            sum_next      = '0;
                            state_next    = (fill_reg == '0) ? ST_TAIL : ST_PUSH;
                        end
                        else if (fill_reg >= CAP_LINE)
                        begin
                            marker_next = 1'b1;
                            fill_next   = '0;
                            oldest_next = '0;
                            sum_next    = '0;
                            state_next  = ST_TAIL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_inc;
                        end
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_inc;
                        sum_next  = sum_reg + q_item.data;
                        if (fill_inc >= psize_eff)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (sum_reg != '0)
                begin
                    sum_next    = sum_reg - rd_data_reg;
                    oldest_next = (oldest_reg == SLOT_LAST) ? '0 : oldest_reg + 1'b1;
                    fill_next   = fill_reg - 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (rd_data_reg == '0)
                begin
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    remain_next   = psize_eff;
                    run_line_next = 1'b0;
                    fill_next     = '0;
                    oldest_next   = '0;
                    sum_next      = '0;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    kind_next      = run_line_reg ? KIND_LINE : KIND_PACKET;
                    last_next      = !run_line_reg && (remain_reg == 7'd1);
                    if (remain_reg == 7'd1)
                    begin
                        state_next = run_line_reg ? ST_TAIL : ST_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                        ptr_next    = (ptr_reg == SLOT_LAST) ? '0 : ptr_reg + 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = marker_reg ? '0 : LINE_FEED;
                    kind_next      = marker_reg ? KIND_OVERFLOW : KIND_LINE;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAMING_MODE:
                begin
                    mode_next   = cfg_data[0];
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                end
                REG_PACKET_SIZE:
                begin
                    psize_next  = cfg_data;
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            sum_reg       <= '0;
            ptr_reg       <= '0;
            remain_reg    <= '0;
            run_line_reg  <= 1'b0;
            marker_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            psize_reg     <= PACKET_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            sum_reg       <= sum_next;
            ptr_reg       <= ptr_next;
            remain_reg    <= remain_next;
            run_line_reg  <= run_line_next;
            marker_reg    <= marker_next;
            mode_reg      <= mode_next;
            psize_reg     <= psize_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        kind_reg     <= kind_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_slot] <= q_item.data;
        end
        rd_data_reg <= store_mem[ptr_next];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP_C)
        else $error("byte count exceeds run cap");

    a_line_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !mode_reg |-> (oldest_reg == '0))
        else $error("line mode window does not start at slot zero");

    a_packet_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg && (state_reg == ST_IDLE)) |-> (fill_reg < psize_eff))
        else $error("full packet window left unchecked");

    a_kind_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((kind_reg == KIND_PACKET) == mode_reg))
        else $error("result kind disagrees with framing mode");

endmodule
`default_nettype wire

[rtl/uart_rx_line_and_packet_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// uart_rx_line_and_packet_framer
// Frames received UART bytes into line-feed ended text lines or checksummed
// fixed-length binary packets.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_ready    rx_byte
//   out      from block out_valid / out_ready  out_byte, last, kind
//   cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that fills a packet window passes through a check state, for the
// read of the oldest byte from the single-read store.
// A run of n bytes then leaves at one byte per cycle, barring output stalls.
// A two-item queue takes up to two items while the engine emits; in_ready
// drops when it is full.
// Reset clears all control state; store contents need no clearing.
// ============================================================================
module uart_rx_line_and_packet_framer
#(
    parameter int unsigned STORE_BYTES = uartfr_pkg::DEFAULT_STORE_BYTES
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [uartfr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [uartfr_pkg::BYTE_W-1:0]          out_byte,
    output logic                                   last,
    output logic [uartfr_pkg::KIND_W-1:0]          kind,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [uartfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uartfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uartfr_pkg::*;

    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    uartfr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    uartfr_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .kind      (kind),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
